### hw/rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants, codes and controller/datapath bundles for the LIFO stack.
// ----------------------------------------------------------------------------
package lss_pkg;

	localparam int DEPTH_DEFAULT = 128;

	localparam int ACT_W  = 3;
	localparam int DATA_W = 32;
	localparam int POS_W  = 7;
	localparam int STAT_W = 3;
	localparam int CNT_W  = 8;

	// request actions
	localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_POP   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SWAP  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DUP   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;
	localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd5;

	// result status
	localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
	localparam logic [STAT_W-1:0] ST_FEW   = 3'd3;
	localparam logic [STAT_W-1:0] ST_INDEX = 3'd4;

	// memory write source / address
	localparam logic [1:0] WSEL_PUSH   = 2'd0; // mem[count]   <= push word
	localparam logic [1:0] WSEL_DUP    = 2'd1; // mem[count]   <= top
	localparam logic [1:0] WSEL_SWAP_A = 2'd2; // mem[count-1] <= second
	localparam logic [1:0] WSEL_SWAP_B = 2'd3; // mem[count-2] <= top

	// count update
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;
	localparam logic [1:0] CNT_CLR  = 2'd3;

	typedef struct packed {
		logic              rd_en;
		logic              rd_peek;
		logic              wr_en;
		logic [1:0]        wr_sel;
		logic [1:0]        cnt_op;
		logic              res_load;
		logic [STAT_W-1:0] res_status;
		logic              res_read;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic few;
		logic idx_bad;
		logic slot_free;
	} stat_t;

endpackage

### hw/rtl/lifo_stack_with_swap_dup_top.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_swap_dup_top
// Bounded LIFO stack of signed 32-bit words with push, pop, swap, dup,
// clear and peek.
// ----------------------------------------------------------------------------
// One request word in gives one result word out (status, read value, count).
// Requests are handled one at a time. Push, clear, unused codes and any
// failing request load their result when taken; pop and peek read first,
// duplicate reads then writes, and swap reads then writes twice, since the
// stack memory has registered reads and a single write port. A finished
// result sits in an output register, and the next request is taken in the
// same cycle that result is taken.
module lifo_stack_with_swap_dup_top #(
	parameter int STACK_DEPTH = lss_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lss_pkg::ACT_W-1:0]         action,
	input  logic signed [lss_pkg::DATA_W-1:0] push_value,
	input  logic [lss_pkg::POS_W-1:0]         peek_position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lss_pkg::STAT_W-1:0]        status,
	output logic signed [lss_pkg::DATA_W-1:0] read_value,
	output logic [lss_pkg::CNT_W-1:0]         entry_count
);
	import lss_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.stat     (stat),
		.cmd      (cmd)
	);

	lss_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.push_value    (push_value),
		.peek_position (peek_position),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.read_value    (read_value),
		.entry_count   (entry_count)
	);

endmodule

### hw/rtl/lss_ctrl.sv
// ----------------------------------------------------------------------------
// lss_ctrl
// Request sequencer: decodes each word and steps the datapath through the
// memory reads and writes it needs.
// ----------------------------------------------------------------------------
module lss_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [lss_pkg::ACT_W-1:0]  action,
	input  lss_pkg::stat_t             stat,
	output lss_pkg::cmd_t              cmd
);
	import lss_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_SWAP2 = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [ACT_W-1:0] op_q;
	logic             accept;

	assign in_stall = !((state_q == S_IDLE) && stat.slot_free);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action)
						ACT_PUSH: begin
							cmd.res_load = 1'b1;
							if (stat.full) begin
								cmd.res_status = ST_FULL;
							end else begin
								cmd.wr_en  = 1'b1;
								cmd.wr_sel = WSEL_PUSH;
								cmd.cnt_op = CNT_INC;
							end
						end
						ACT_POP: begin
							if (stat.empty) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_EMPTY;
							end else begin
								cmd.rd_en = 1'b1;
								state_d   = S_READ;
							end
						end
						ACT_SWAP: begin
							if (stat.few) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_FEW;
							end else begin
								cmd.rd_en = 1'b1;
								state_d   = S_READ;
							end
						end
						ACT_DUP: begin
							if (stat.empty) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_EMPTY;
							end else if (stat.full) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_FULL;
							end else begin
								cmd.rd_en = 1'b1;
								state_d   = S_READ;
							end
						end
						ACT_CLEAR: begin
							cmd.res_load = 1'b1;
							cmd.cnt_op   = CNT_CLR;
						end
						ACT_PEEK: begin
							if (stat.empty) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_EMPTY;
							end else if (stat.idx_bad) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_INDEX;
							end else begin
								cmd.rd_en   = 1'b1;
								cmd.rd_peek = 1'b1;
								state_d     = S_READ;
							end
						end
						default: begin
							cmd.res_load = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				// read data is registered and valid here
				case (op_q)
					ACT_DUP: begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WSEL_DUP;
						state_d    = S_DONE;
					end
					ACT_SWAP: begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WSEL_SWAP_A;
						state_d    = S_SWAP2;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SWAP2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WSEL_SWAP_B;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (stat.slot_free) begin
					cmd.res_load = 1'b1;
					cmd.res_read = (op_q == ACT_POP) || (op_q == ACT_PEEK);
					if (op_q == ACT_POP) begin
						cmd.cnt_op = CNT_DEC;
					end else if (op_q == ACT_DUP) begin
						cmd.cnt_op = CNT_INC;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= ACT_PUSH;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= action;
			end
		end
	end

endmodule

### hw/rtl/lss_dp.sv
// ----------------------------------------------------------------------------
// lss_dp
// Stack datapath: entry memory with two registered read ports, fill count
// and the result register.
// ----------------------------------------------------------------------------
module lss_dp #(
	parameter int STACK_DEPTH = lss_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lss_pkg::cmd_t                     cmd,
	output lss_pkg::stat_t                    stat,
	input  logic signed [lss_pkg::DATA_W-1:0] push_value,
	input  logic [lss_pkg::POS_W-1:0]         peek_position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lss_pkg::STAT_W-1:0]        status,
	output logic signed [lss_pkg::DATA_W-1:0] read_value,
	output logic [lss_pkg::CNT_W-1:0]         entry_count
);
	import lss_pkg::*;

	localparam int AW   = $clog2(STACK_DEPTH);
	localparam int CW   = $clog2(STACK_DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	logic [DATA_W-1:0] entry_mem [STACK_DEPTH];
	logic [DATA_W-1:0] rd_a_q, rd_b_q;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     cnt_m1, cnt_m2;
	logic [CMPW-1:0]   pos_x, cnt_x;
	logic [AW-1:0]     rd_addr_a, rd_addr_b, wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [CW+CNT_W-1:0] count_ext;

	logic                     out_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic [CNT_W-1:0]         entry_count_q;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign pos_x  = CMPW'(peek_position);
	assign cnt_x  = CMPW'(count_q);

	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q >= DEPTH_C);
	assign stat.few       = (count_q < CW'(2));
	assign stat.idx_bad   = (pos_x >= cnt_x);
	assign stat.slot_free = !out_valid_q || !out_stall;

	// port a reads the top or the peeked slot, port b the entry below the top
	assign rd_addr_a = cmd.rd_peek ? pos_x[AW-1:0] : cnt_m1[AW-1:0];
	assign rd_addr_b = cnt_m2[AW-1:0];

	always_comb begin
		wr_addr = count_q[AW-1:0];
		wr_data = push_value;
		case (cmd.wr_sel)
			WSEL_PUSH: begin
				wr_addr = count_q[AW-1:0];
				wr_data = push_value;
			end
			WSEL_DUP: begin
				wr_addr = count_q[AW-1:0];
				wr_data = rd_a_q;
			end
			WSEL_SWAP_A: begin
				wr_addr = cnt_m1[AW-1:0];
				wr_data = rd_b_q;
			end
			WSEL_SWAP_B: begin
				wr_addr = cnt_m2[AW-1:0];
				wr_data = rd_a_q;
			end
			default: begin
				wr_addr = count_q[AW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_a_q <= entry_mem[rd_addr_a];
			rd_b_q <= entry_mem[rd_addr_b];
		end
	end

	always_comb begin
		case (cmd.cnt_op)
			CNT_INC:  count_d = count_q + CW'(1);
			CNT_DEC:  count_d = cnt_m1;
			CNT_CLR:  count_d = '0;
			default:  count_d = count_q;
		endcase
	end

	// count reported modulo 256
	assign count_ext = {{CNT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q      <= cmd.res_status;
			read_value_q  <= cmd.res_read ? rd_a_q : '0;
			entry_count_q <= count_ext[CNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_count_q;

endmodule

### dv/stack_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_result_check
// Watches the request and result channels of the LIFO stack, keeps a shadow
// copy of the stack to predict every result word and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module stack_result_check
	import lss_pkg::*;
#(
	parameter int STACK_DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [DATA_W-1:0] push_value,
	input  logic [POS_W-1:0]         peek_position,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [STAT_W-1:0]        status,
	input  logic signed [DATA_W-1:0] read_value,
	input  logic [CNT_W-1:0]         entry_count,
	output int                       mismatch_count,
	output int                       outstanding_results
);

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         entry_count;
	} stack_result_t;

	logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
	int unsigned              shadow_fill = 0;
	stack_result_t            expected_results [$];

	initial begin
		mismatch_count = 0;
		outstanding_results = 0;
	end

	// applies one request to the shadow stack and returns the result word
	function automatic stack_result_t predict_request(input logic [ACT_W-1:0] act,
			input logic signed [DATA_W-1:0] word, input logic [POS_W-1:0] pos);
		stack_result_t            res;
		logic signed [DATA_W-1:0] held;
		res.status = ST_OK;
		res.read_value = '0;
		case (act)
		ACT_PUSH: begin
			if (shadow_fill >= STACK_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				shadow_words[shadow_fill] = word;
				shadow_fill++;
			end
		end
		ACT_POP: begin
			if (shadow_fill == 0) begin
				res.status = ST_EMPTY;
			end else begin
				shadow_fill--;
				res.read_value = shadow_words[shadow_fill];
			end
		end
		ACT_SWAP: begin
			if (shadow_fill < 2) begin
				res.status = ST_FEW;
			end else begin
				held = shadow_words[shadow_fill - 1];
				shadow_words[shadow_fill - 1] = shadow_words[shadow_fill - 2];
				shadow_words[shadow_fill - 2] = held;
			end
		end
		ACT_DUP: begin
			if (shadow_fill == 0) begin
				res.status = ST_EMPTY;
			end else if (shadow_fill >= STACK_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				shadow_words[shadow_fill] = shadow_words[shadow_fill - 1];
				shadow_fill++;
			end
		end
		ACT_CLEAR: begin
			shadow_fill = 0;
		end
		ACT_PEEK: begin
			if (shadow_fill == 0) begin
				res.status = ST_EMPTY;
			end else if (pos >= shadow_fill) begin
				res.status = ST_INDEX;
			end else begin
				res.read_value = shadow_words[pos];
			end
		end
		default: begin
		end
		endcase
		res.entry_count = CNT_W'(shadow_fill);
		return res;
	endfunction

	task automatic flag_failure(input string note);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s; got status %0d value %0d count %0d", $time, note,
				status, read_value, entry_count);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stack_result_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			expected_results.delete();
		end else begin
			// result first: it belongs to an older request than one taken now
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					flag_failure("result word with no request pending");
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status || read_value !== want.read_value ||
							entry_count !== want.entry_count) begin
						flag_failure($sformatf("mismatch, expected status %0d value %0d count %0d",
							want.status, want.read_value, want.entry_count));
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_request(action, push_value, peek_position));
			end
		end
		outstanding_results = expected_results.size();
	end

endmodule

### dv/lifo_stack_with_swap_dup_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_swap_dup_top_tb
// Drives directed corner requests and then random fill, drain and mixed
// request streams into the LIFO stack with bursty input and a patterned
// output stall; the result checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module lifo_stack_with_swap_dup_top_tb;
	import lss_pkg::*;

	localparam int STACK_DEPTH   = DEPTH_DEFAULT;
	localparam int REQUEST_COUNT = 1850;

	// action codes the block treats as no operation
	localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

	// random stream flavors
	localparam int MIX_FILL  = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_ANY   = 2;

	// receiver stall patterns
	localparam int STALL_NONE     = 0;
	localparam int STALL_LIGHT    = 1;
	localparam int STALL_HEAVY    = 2;
	localparam int STALL_PERIODIC = 3;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [ACT_W-1:0]         action = ACT_PUSH;
	logic signed [DATA_W-1:0] push_value = '0;
	logic [POS_W-1:0]         peek_position = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]         entry_count;
	int                       mismatch_count;
	int                       outstanding_results;

	int stim_depth = 0; // fill level as the stimulus sees it, used to aim peeks
	int burst_left = 0;
	int stall_mode = STALL_NONE;
	int stall_window = 0;
	int stall_tick = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	lifo_stack_with_swap_dup_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.push_value(push_value),
		.peek_position(peek_position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.read_value(read_value),
		.entry_count(entry_count)
	);

	stack_result_check #(
		.STACK_DEPTH(STACK_DEPTH)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.push_value(push_value),
		.peek_position(peek_position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.read_value(read_value),
		.entry_count(entry_count),
		.mismatch_count(mismatch_count),
		.outstanding_results(outstanding_results)
	);

	always @(posedge clk) begin
		if (stall_window == 0) begin
			stall_mode <= $urandom_range(STALL_NONE, STALL_PERIODIC);
			stall_window <= $urandom_range(16, 80);
		end else begin
			stall_window <= stall_window - 1;
		end
		stall_tick <= stall_tick + 1;
		case (stall_mode)
		STALL_NONE: begin
			out_stall <= 1'b0;
		end
		STALL_LIGHT: begin
			out_stall <= ($urandom_range(0, 99) < 25);
		end
		STALL_HEAVY: begin
			out_stall <= ($urandom_range(0, 99) < 70);
		end
		default: begin
			out_stall <= ((stall_tick % 5) < 2);
		end
		endcase
	end

	// presents one request word and returns right after the edge that takes it
	task automatic send_request(input logic [ACT_W-1:0] act,
			input logic signed [DATA_W-1:0] word, input logic [POS_W-1:0] pos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		push_value <= word;
		peek_position <= pos;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		case (act)
		ACT_PUSH: begin
			if (stim_depth < STACK_DEPTH) stim_depth++;
		end
		ACT_POP: begin
			if (stim_depth > 0) stim_depth--;
		end
		ACT_DUP: begin
			if (stim_depth > 0 && stim_depth < STACK_DEPTH) stim_depth++;
		end
		ACT_CLEAR: begin
			stim_depth = 0;
		end
		default: begin
		end
		endcase
	endtask

	initial begin
		int               mix;
		int               segment_left;
		int               roll;
		logic [ACT_W-1:0] act;
		logic [POS_W-1:0] pos;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack, one entry, two entries, unused codes, clear
		send_request(ACT_POP, 32'sd0, 7'd0);
		send_request(ACT_SWAP, 32'sd0, 7'd0);
		send_request(ACT_DUP, 32'sd0, 7'd0);
		send_request(ACT_PEEK, 32'sd0, 7'd0);
		send_request(ACT_PUSH, 32'sh8000_0000, 7'd0);
		send_request(ACT_SWAP, 32'sd0, 7'd0);
		send_request(ACT_PUSH, 32'sh7fff_ffff, 7'd127);
		send_request(ACT_SWAP, 32'sd0, 7'd0);
		send_request(ACT_PEEK, 32'sd0, 7'd0);
		send_request(ACT_PEEK, 32'sd0, 7'd1);
		send_request(ACT_PEEK, 32'sd0, 7'd2);
		send_request(ACT_PEEK, 32'sd0, 7'd127);
		send_request(ACT_DUP, 32'sd0, 7'd0);
		send_request(ACT_POP, 32'sd0, 7'd0);
		send_request(ACT_POP, 32'sd0, 7'd0);
		send_request(ACT_POP, 32'sd0, 7'd0);
		send_request(ACT_PUSH, -32'sd1, 7'd0);
		send_request(ACT_PUSH, 32'sd0, 7'd0);
		send_request(ACT_SPARE_A, 32'sh5555_aaaa, 7'd127);
		send_request(ACT_SPARE_B, -32'sd1, 7'd64);
		send_request(ACT_CLEAR, 32'sd0, 7'd0);
		send_request(ACT_POP, 32'sd0, 7'd0);
		send_request(ACT_PEEK, 32'sd0, 7'd0);
		send_request(ACT_PUSH, 32'sh5555_aaaa, 7'd0);

		segment_left = 0;
		mix = MIX_FILL;
		for (int n = 0; n < REQUEST_COUNT; n++) begin
			if (segment_left == 0) begin
				// the first stream is always a fill stream
				mix = (n == 0) ? MIX_FILL : $urandom_range(MIX_FILL, MIX_ANY);
				segment_left = (mix == MIX_FILL) ? $urandom_range(150, 260) :
					$urandom_range(40, 200);
			end
			segment_left--;
			roll = $urandom_range(0, 99);
			case (mix)
			MIX_FILL: begin
				act = (roll < 60) ? ACT_PUSH : (roll < 85) ? ACT_DUP :
					(roll < 90) ? ACT_SWAP : (roll < 95) ? ACT_PEEK : ACT_POP;
			end
			MIX_DRAIN: begin
				act = (roll < 55) ? ACT_POP : (roll < 70) ? ACT_PEEK :
					(roll < 80) ? ACT_SWAP : (roll < 90) ? ACT_PUSH :
					(roll < 97) ? ACT_DUP : ACT_CLEAR;
			end
			default: begin
				act = ACT_W'($urandom_range(0, 7));
				if (act == ACT_CLEAR && roll >= 15) act = ACT_PEEK;
			end
			endcase
			if (stim_depth > 0 && $urandom_range(0, 3) != 0) begin
				pos = POS_W'($urandom_range(0, stim_depth - 1));
			end else begin
				pos = POS_W'($urandom_range(0, 127));
			end
			send_request(act, $urandom, pos);
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding_results != 0);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && outstanding_results == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### lifo_stack_with_swap_dup_top.f
hw/rtl/lss_pkg.sv
hw/rtl/lss_ctrl.sv
hw/rtl/lss_dp.sv
hw/rtl/lifo_stack_with_swap_dup_top.sv
dv/stack_result_check.sv
dv/lifo_stack_with_swap_dup_top_tb.sv
